/* src/slb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slb_pkg;

   localparam int unsigned COL_W   = 13;
   localparam int unsigned START_W = 12;
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned LANES   = 3;
   localparam int unsigned ACC_W   = COL_W + PIX_W;

   localparam logic CSR_OVERLAP_START   = 1'b0;
   localparam logic CSR_REFERENCE_WIDTH = 1'b1;

   localparam int unsigned RESET_REF_WIDTH = 4096;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [LANES-1:0] rgb_type;

   typedef struct packed {
      logic             blend;
      logic [COL_W-1:0] span;
      logic [COL_W-1:0] k;
      logic [COL_W-1:0] kc;
      rgb_type          ref_px;
      rgb_type          warp_px;
   } front_type;

   typedef struct packed {
      logic                        blend;
      logic [COL_W-1:0]            span;
      logic [LANES-1:0][COL_W-1:0] rem;
      rgb_type                     low;
   } div_type;

endpackage

`default_nettype wire

/* src/slb_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module slb_front
   import slb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [START_W-1:0] cfg_start,
   input  wire logic [COL_W-1:0]   cfg_width,
   input  wire logic               up_valid,
   input  wire logic [COL_W-1:0]   up_column,
   input  wire rgb_type            up_ref,
   input  wire rgb_type            up_warp,
   output logic                    up_ready,
   output logic                    dn_valid,
   output front_type               dn_data,
   input  wire logic               dn_ready
);

   logic      valid_ff, valid_in;
   front_type data_ff, data_in;

   logic [COL_W-1:0] start_ext;
   logic             past_ref, left_of_ovl, black;

   assign start_ext   = {1'b0, cfg_start};
   assign past_ref    = up_column >= cfg_width;
   assign left_of_ovl = up_column < start_ext;
   assign black       = (up_warp[0] == '0) && (up_warp[1] == '0) && (up_warp[2] == '0);

   always_comb begin
      data_in.blend   = 1'b0;
      data_in.span    = cfg_width - start_ext;
      data_in.k       = up_column - start_ext;
      data_in.kc      = cfg_width - up_column;
      data_in.warp_px = up_warp;
      data_in.ref_px  = up_ref;
      if (past_ref) begin
         data_in.ref_px = up_warp;
      end else if (!left_of_ovl && !black) begin
         data_in.blend = 1'b1;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* src/slb_mult.sv */
`timescale 1ns / 1ps
`default_nettype none

module slb_mult
   import slb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      up_valid,
   input  wire front_type up_data,
   output logic           up_ready,
   output logic           dn_valid,
   output div_type        dn_data,
   input  wire logic      dn_ready
);

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;

   always_comb begin
      logic [ACC_W-1:0] acc;
      data_in.blend = up_data.blend;
      data_in.span  = up_data.span;
      for (int c = 0; c < LANES; c++) begin
         acc = ACC_W'(up_data.ref_px[c]) * ACC_W'(up_data.kc)
             + ACC_W'(up_data.warp_px[c]) * ACC_W'(up_data.k);
         if (up_data.blend) begin
            data_in.rem[c] = acc[ACC_W-1:PIX_W];
            data_in.low[c] = acc[PIX_W-1:0];
         end else begin
            data_in.rem[c] = '0;
            data_in.low[c] = up_data.ref_px[c];
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* src/slb_div_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module slb_div_step
   import slb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    up_valid,
   input  wire div_type up_data,
   output logic         up_ready,
   output logic         dn_valid,
   output div_type      dn_data,
   input  wire logic    dn_ready
);

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;

   // two restoring steps per lane, quotient bits shift into the low byte
   always_comb begin
      logic [COL_W:0]   trial;
      logic [COL_W-1:0] rem;
      pix_type          low;
      data_in = up_data;
      for (int c = 0; c < LANES; c++) begin
         rem = up_data.rem[c];
         low = up_data.low[c];
         for (int s = 0; s < 2; s++) begin
            trial = {rem, low[PIX_W-1]};
            if (trial >= {1'b0, up_data.span}) begin
               rem = COL_W'(trial - {1'b0, up_data.span});
               low = {low[PIX_W-2:0], 1'b1};
            end else begin
               rem = trial[COL_W-1:0];
               low = {low[PIX_W-2:0], 1'b0};
            end
         end
         if (up_data.blend) begin
            data_in.rem[c] = rem;
            data_in.low[c] = low;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

/* src/seam_linear_blend.sv */
// an accepted item passes through registered stages to its result (decode, multiply, four divide stages)
// throughput: one item per cycle while rsp_stall is low; the quotient takes four stages of two restoring steps each
// every stage holds its own valid bit, so a stalled output fills bubbles before req_stall rises
// reset (synchronous, active high) empties the pipeline, overlap_start to 0 and
// reference_width to 4096, saturated to MAX_WIDTH
`timescale 1ns / 1ps
`default_nettype none

module seam_linear_blend
   import slb_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 4096
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [COL_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [COL_W-1:0] req_column,
   input  wire logic [PIX_W-1:0] req_ref_c0,
   input  wire logic [PIX_W-1:0] req_ref_c1,
   input  wire logic [PIX_W-1:0] req_ref_c2,
   input  wire logic [PIX_W-1:0] req_warp_c0,
   input  wire logic [PIX_W-1:0] req_warp_c1,
   input  wire logic [PIX_W-1:0] req_warp_c2,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [PIX_W-1:0]      rsp_out_c0,
   output logic [PIX_W-1:0]      rsp_out_c1,
   output logic [PIX_W-1:0]      rsp_out_c2
);

   localparam logic [COL_W-1:0] RESET_WIDTH =
      (RESET_REF_WIDTH > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : COL_W'(RESET_REF_WIDTH);

   localparam int unsigned DIV_STAGES = PIX_W / 2;

   logic [START_W-1:0] start_ff;
   logic [COL_W-1:0]   width_ff, width_in;

   assign width_in = (32'(csr_wdata) > MAX_WIDTH) ? COL_W'(MAX_WIDTH) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         width_ff <= RESET_WIDTH;
      end else if (csr_write) begin
         case (csr_index)
            CSR_OVERLAP_START:   start_ff <= csr_wdata[START_W-1:0];
            CSR_REFERENCE_WIDTH: width_ff <= width_in;
            default: ;
         endcase
      end
   end

   rgb_type   req_ref, req_warp;
   logic      front_ready, front_valid, mult_ready, mult_valid;
   front_type front_data;
   div_type   mult_data;

   logic    div_valid [DIV_STAGES+1];
   logic    div_ready [DIV_STAGES+1];
   div_type div_data  [DIV_STAGES+1];

   assign req_ref  = {req_ref_c2, req_ref_c1, req_ref_c0};
   assign req_warp = {req_warp_c2, req_warp_c1, req_warp_c0};

   slb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg_start (start_ff),
      .cfg_width (width_ff),
      .up_valid  (req_valid),
      .up_column (req_column),
      .up_ref    (req_ref),
      .up_warp   (req_warp),
      .up_ready  (front_ready),
      .dn_valid  (front_valid),
      .dn_data   (front_data),
      .dn_ready  (mult_ready)
   );

   slb_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .up_valid (front_valid),
      .up_data  (front_data),
      .up_ready (mult_ready),
      .dn_valid (mult_valid),
      .dn_data  (mult_data),
      .dn_ready (div_ready[0])
   );

   assign div_valid[0] = mult_valid;
   assign div_data[0]  = mult_data;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      slb_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[i]),
         .up_data  (div_data[i]),
         .up_ready (div_ready[i]),
         .dn_valid (div_valid[i+1]),
         .dn_data  (div_data[i+1]),
         .dn_ready (div_ready[i+1])
      );
   end

   assign div_ready[DIV_STAGES] = !rsp_stall;

   assign req_stall  = !front_ready;
   assign rsp_valid  = div_valid[DIV_STAGES];
   assign rsp_out_c0 = div_data[DIV_STAGES].low[0];
   assign rsp_out_c1 = div_data[DIV_STAGES].low[1];
   assign rsp_out_c2 = div_data[DIV_STAGES].low[2];

endmodule

`default_nettype wire
